// File: rtl/ptme_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page table map/unmap engine.
// No dependencies.
package ptme_pkg;

    // Request opcodes
    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    // Table geometry
    localparam int IDX_W      = 9;
    localparam int ENTRY_W    = 64;
    localparam int VA_W       = 48;
    localparam int PA_W       = 52;
    localparam int FLAGS_W    = 12;
    localparam int BASE_W     = 40;
    localparam int FRAME_W    = 52;
    localparam int SUM_W      = 53;

    // Entry bit positions
    localparam int E_PRESENT_BIT = 0;
    localparam int E_LARGE_BIT   = 7;
    localparam logic [FLAGS_W-1:0] E_PRESENT = 12'h001;
    localparam logic [FLAGS_W-1:0] E_WRITE   = 12'h002;

    // Walk levels
    localparam logic [1:0] LVL_ROOT     = 2'd0;
    localparam logic [1:0] LVL_DIR1     = 2'd1;
    localparam logic [1:0] LVL_DIR2     = 2'd2;
    localparam logic [1:0] LVL_LEAF     = 2'd3;

    localparam logic [BASE_W-1:0] POOL_BASE_RESET = 40'd112;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_LARGE     = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_OUTSIDE   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ALLOC,
        S_LEAF,
        S_FINISH
    } state_t;

    typedef enum logic {
        UOP_ADD,
        UOP_SUB
    } unit_op_t;

    // Result of the shared address unit
    typedef struct packed {
        logic             in_pool;
        logic [SUM_W-1:0] sum;
    } unit_res_t;

endpackage

// File: rtl/ptme_table_ram.sv
`timescale 1ns / 1ps
// Table memory: one write port, one registered read port, zero sweep after reset.
// Depends on ptme_pkg.
module ptme_table_ram
    import ptme_pkg::*;
#(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data,
    output logic               busy
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               we;
    logic [ADDR_W-1:0]  wa;
    logic [ENTRY_W-1:0] wd;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    // Sweep owns the write port until it completes
    always_comb
    begin
        we = wr_en;
        wa = wr_addr;
        wd = wr_data;
        if (clr_active_reg)
        begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

// File: rtl/ptme_addr_unit.sv
`timescale 1ns / 1ps
// Shared add/subtract unit: frame-to-pool-page check and new table address.
// Depends on ptme_pkg.
module ptme_addr_unit
    import ptme_pkg::*;
#(
    parameter int POOL_PAGES = 16
)
(
    input  unit_op_t            uop,
    input  logic [FRAME_W-1:0]  a,
    input  logic [BASE_W-1:0]   base,
    output unit_res_t           res
);

    logic [SUM_W-1:0] op_b;
    logic [SUM_W-1:0] sum;

    // Subtract as add of inverted operand plus one
    assign op_b = (uop == UOP_SUB) ? ~{13'd0, base} : {13'd0, base};
    assign sum  = {1'b0, a} + op_b + SUM_W'(uop == UOP_SUB);

    // Top bit set means frame was below the base
    assign res.sum     = sum;
    assign res.in_pool = !sum[SUM_W-1] && (sum[FRAME_W-1:0] < FRAME_W'(POOL_PAGES));

endmodule

// File: rtl/page_table_map_unmap_engine.sv
`timescale 1ns / 1ps
// Top level of the page table map/unmap engine: sequencer and output register.
// Depends on ptme_pkg, ptme_table_ram, ptme_addr_unit.
//
// Usage
//   Input channel (in_valid/in_stall): one word per request, op, virt_addr,
//   phys_addr, page_flags. in_stall is high while a request is in the walk.
//   Output channel (out_valid/out_stall): one word per request, status,
//   invalidate, invalidate_addr. The result sits in an output register, so
//   the next request is accepted while the previous result waits.
//   Config channel (cfg_valid/cfg_ready): writes table_pool_base; write it
//   only while no request is outstanding. cfg_ready is always high.
//   Walk: each directory level is a read state then an evaluate state, plus
//   an allocate state for each table allocated, then one leaf write and a
//   finish state that loads the output register. Early exits go straight to
//   finish. One request is in the walk at a time; the next is accepted once
//   the finish state is left. The table memory and shared adder serve one walk.
//   Reset: the table memory is swept to zero, one entry per cycle, over all
//   POOL_PAGES * 512 entries (8192 at default); in_stall is high until done.
//   Stall: if out_stall holds a result, the next finished request waits in
//   the finish state until the output register frees.
module page_table_map_unmap_engine
    import ptme_pkg::*;
#(
    parameter int POOL_PAGES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [VA_W-1:0]     virt_addr,
    input  logic [PA_W-1:0]     phys_addr,
    input  logic [FLAGS_W-1:0]  page_flags,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic                invalidate,
    output logic [VA_W-1:0]     invalidate_addr,
    // config channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BASE_W-1:0]   table_pool_base
);

    localparam int PAGE_W = $clog2(POOL_PAGES);
    localparam int NF_W   = $clog2(POOL_PAGES + 1);
    localparam int DEPTH  = POOL_PAGES * (1 << IDX_W);
    localparam int ADDR_W = PAGE_W + IDX_W;

    state_t state_reg, state_next;

    logic [BASE_W-1:0]   base_reg;
    logic [NF_W-1:0]     next_free_reg, next_free_next;
    logic [1:0]          lvl_reg, lvl_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    status_t             res_status_reg, res_status_next;

    // latched request
    logic                op_reg, op_next;
    logic [VA_W-1:0]     va_reg, va_next;
    logic [PA_W-1:0]     pa_reg, pa_next;
    logic [FLAGS_W-1:0]  fl_reg, fl_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic                inv_reg, inv_next;
    logic [VA_W-1:0]     inv_addr_reg, inv_addr_next;

    // memory and unit hookup
    logic                ram_busy;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [IDX_W-1:0]    idx;
    unit_op_t            uop;
    logic [FRAME_W-1:0]  unit_a;
    unit_res_t           ures;

    logic                in_acc, out_free;
    logic                ent_present, ent_large, pool_full;

    ptme_table_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ram_we),
        .wr_addr (ram_addr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_addr),
        .rd_data (ram_rdata),
        .busy    (ram_busy)
    );

    ptme_addr_unit #(
        .POOL_PAGES (POOL_PAGES)
    ) u_unit (
        .uop  (uop),
        .a    (unit_a),
        .base (base_reg),
        .res  (ures)
    );

    // Index field of the current level
    always_comb
    begin
        case (lvl_reg)
            LVL_ROOT: idx = va_reg[47:39];
            LVL_DIR1: idx = va_reg[38:30];
            LVL_DIR2: idx = va_reg[29:21];
            LVL_LEAF: idx = va_reg[20:12];
            default:  idx = va_reg[20:12];
        endcase
    end

    assign ram_addr    = {page_reg, idx};
    assign in_stall    = (state_reg != S_IDLE) || ram_busy;
    assign in_acc      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign ent_present = ram_rdata[E_PRESENT_BIT];
    // large bit is ignored at the root
    assign ent_large   = ram_rdata[E_LARGE_BIT] && (lvl_reg != LVL_ROOT);
    assign pool_full   = next_free_reg >= NF_W'(POOL_PAGES);

    // Shared unit: subtract (frame - base) when checking, add (base + page) to allocate
    assign uop    = (state_reg == S_ALLOC) ? UOP_ADD : UOP_SUB;
    assign unit_a = (state_reg == S_ALLOC) ? FRAME_W'(next_free_reg)
                                           : ram_rdata[ENTRY_W-1:12];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (ent_present)
                begin
                    if (ent_large || !ures.in_pool)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = (lvl_reg == LVL_DIR2) ? S_LEAF : S_READ;
                    end
                end
                else if (op_reg == OP_UNMAP || pool_full)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                state_next = (lvl_reg == LVL_DIR2) ? S_LEAF : S_READ;
            end
            S_LEAF:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        op_next         = op_reg;
        va_next         = va_reg;
        pa_next         = pa_reg;
        fl_next         = fl_reg;
        lvl_next        = lvl_reg;
        page_next       = page_reg;
        next_free_next  = next_free_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_wdata       = '0;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        inv_next        = inv_reg;
        inv_addr_next   = inv_addr_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next         = op;
                    va_next         = virt_addr;
                    pa_next         = phys_addr;
                    fl_next         = page_flags;
                    lvl_next        = LVL_ROOT;
                    page_next       = '0;
                    res_status_next = ST_DONE;
                end
            end
            S_READ:
            begin
                ram_re = 1'b1;
            end
            S_EVAL:
            begin
                if (ent_present)
                begin
                    if (ent_large)
                    begin
                        res_status_next = ST_LARGE;
                    end
                    else if (!ures.in_pool)
                    begin
                        res_status_next = ST_OUTSIDE;
                    end
                    else
                    begin
                        page_next = ures.sum[PAGE_W-1:0];
                        lvl_next  = lvl_reg + 1'b1;
                    end
                end
                else if (op_reg == OP_UNMAP)
                begin
                    res_status_next = ST_ABSENT;
                end
                else if (pool_full)
                begin
                    res_status_next = ST_EXHAUSTED;
                end
            end
            S_ALLOC:
            begin
                // link new table: (base + page) << 12 | present | write | flags
                ram_we         = 1'b1;
                ram_wdata      = {11'd0, ures.sum[BASE_W:0], fl_reg | E_PRESENT | E_WRITE};
                page_next      = next_free_reg[PAGE_W-1:0];
                next_free_next = next_free_reg + 1'b1;
                lvl_next       = lvl_reg + 1'b1;
            end
            S_LEAF:
            begin
                ram_we = 1'b1;
                if (op_reg == OP_MAP)
                begin
                    ram_wdata = {12'd0, pa_reg[PA_W-1:12], fl_reg | E_PRESENT};
                end
                res_status_next = ST_DONE;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    inv_next        = (res_status_reg == ST_DONE);
                    inv_addr_next   = (res_status_reg == ST_DONE) ? va_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_reg       <= POOL_BASE_RESET;
            next_free_reg  <= NF_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= table_pool_base;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        va_reg         <= va_next;
        pa_reg         <= pa_next;
        fl_reg         <= fl_next;
        lvl_reg        <= lvl_next;
        page_reg       <= page_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        inv_reg        <= inv_next;
        inv_addr_reg   <= inv_addr_next;
    end

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign invalidate      = inv_reg;
    assign invalidate_addr = inv_addr_reg;

endmodule

// File: rtl/ptme_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the page table map/unmap engine, bound to the top.
// Depends on ptme_pkg and page_table_map_unmap_engine.
module ptme_checker
    import ptme_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [2:0]       status,
    input  logic             invalidate,
    input  logic [VA_W-1:0]  invalidate_addr
);

    // One request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while previous walk in flight");

    // Held result word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)
            && $stable(invalidate) && $stable(invalidate_addr)))
        else $error("stalled result changed");

    // Invalidate only with a completed walk
    a_inv_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (invalidate == (status == ST_DONE)))
        else $error("invalidate does not match status");

    // No flush address without a flush
    a_inv_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !invalidate) |-> (invalidate_addr == '0))
        else $error("invalidate_addr nonzero without invalidate");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_DONE || status == ST_LARGE || status == ST_EXHAUSTED
            || status == ST_ABSENT || status == ST_OUTSIDE))
        else $error("status code out of range");

endmodule

bind page_table_map_unmap_engine ptme_checker u_ptme_checker (.*);

// File: verif/page_table_map_unmap_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_table_map_unmap_engine: directed table, then random walks.
// Depends on ptme_pkg and the engine RTL; keeps its own shadow of the table pool.
module page_table_map_unmap_engine_tb;
    import ptme_pkg::*;

    localparam int POOL_PAGES       = 16;
    localparam int TABLE_ENTRIES    = 512;
    // Longest quiet stretch in a good run is the table clear after reset.
    localparam int WATCHDOG_LIMIT   = 25000;
    localparam int LONG_HOLD_CYCLES = 300;
    // Room for two full walks before the final verdict.
    localparam int DRAIN_CYCLES     = 24;

    typedef struct {
        status_t           walk_status;
        logic              flush;
        logic [VA_W-1:0]   flush_addr;
    } walk_result_t;

    typedef enum logic {
        ROW_REQUEST,
        ROW_SET_BASE
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic                req_op;
        logic [VA_W-1:0]     va;
        logic [PA_W-1:0]     pa;
        logic [FLAGS_W-1:0]  flags;
        logic [BASE_W-1:0]   base;
        bit                  pinned;     // expected word typed into the row
        status_t             pin_status;
        logic                pin_flush;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                op;
    logic [VA_W-1:0]     virt_addr;
    logic [PA_W-1:0]     phys_addr;
    logic [FLAGS_W-1:0]  page_flags;
    logic                out_valid;
    logic                out_stall;
    logic [2:0]          status;
    logic                invalidate;
    logic [VA_W-1:0]     invalidate_addr;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [BASE_W-1:0]   table_pool_base;

    // Shadow copy of the engine state: pool contents, bump counter, base frame.
    logic [ENTRY_W-1:0]  tables_shadow [POOL_PAGES*TABLE_ENTRIES];
    int unsigned         next_free_shadow;
    logic [BASE_W-1:0]   pool_base_shadow;

    walk_result_t        pending_results[$];
    logic [VA_W-1:0]     mapped_vas[$];
    stim_row_t           directed_rows[$];

    bit                  idling_on    = 1'b1;
    bit                  hold_request = 1'b0;
    int unsigned         mismatches   = 0;
    int unsigned         requests_sent = 0;
    int unsigned         base_writes  = 0;
    int unsigned         status_hits [8];

    page_table_map_unmap_engine #(
        .POOL_PAGES      (POOL_PAGES)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .virt_addr       (virt_addr),
        .phys_addr       (phys_addr),
        .page_flags      (page_flags),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .invalidate      (invalidate),
        .invalidate_addr (invalidate_addr),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .table_pool_base (table_pool_base)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Walk predictor. Mirrors one request against the shadow pool and
    // returns the word the engine must produce. Levels 0..2 are directory
    // levels (root, then two more); the fourth index picks the leaf.
    // ------------------------------------------------------------------
    function automatic walk_result_t walk_tables(input logic req_op,
                                                 input logic [VA_W-1:0] va,
                                                 input logic [PA_W-1:0] pa,
                                                 input logic [FLAGS_W-1:0] fl);
        walk_result_t        res;
        int unsigned         page;
        int unsigned         slot_idx;
        logic [ENTRY_W-1:0]  ent;
        logic [63:0]         frame;
        logic [63:0]         base64;
        int                  lvl;
        res.walk_status = ST_DONE;
        res.flush       = 1'b0;
        res.flush_addr  = '0;
        page            = 0;
        base64          = {24'd0, pool_base_shadow};
        for (lvl = 0; lvl < 3; lvl++)
        begin
            if (res.walk_status == ST_DONE)
            begin
                slot_idx = page * TABLE_ENTRIES + int'(va[VA_W-1-IDX_W*lvl -: IDX_W]);
                ent      = tables_shadow[slot_idx];
                if (ent[E_PRESENT_BIT])
                begin
                    frame = {12'd0, ent[ENTRY_W-1:12]};
                    // the large bit means nothing in a root entry
                    if (lvl > 0 && ent[E_LARGE_BIT])
                        res.walk_status = ST_LARGE;
                    else if (frame < base64 || frame - base64 >= 64'(POOL_PAGES))
                        res.walk_status = ST_OUTSIDE;
                    else
                        page = int'(frame - base64);
                end
                else if (req_op == OP_UNMAP)
                    res.walk_status = ST_ABSENT;
                else if (next_free_shadow >= POOL_PAGES)
                    res.walk_status = ST_EXHAUSTED;
                else
                begin
                    // new directory entry: table address | present | write | request flags
                    tables_shadow[slot_idx] = ((base64 + 64'(next_free_shadow)) << 12)
                                            | {52'd0, fl | E_PRESENT | E_WRITE};
                    page = next_free_shadow;
                    next_free_shadow++;
                end
            end
        end
        if (res.walk_status == ST_DONE)
        begin
            // unmap clears the leaf even when it was already empty
            slot_idx = page * TABLE_ENTRIES + int'(va[20:12]);
            tables_shadow[slot_idx] = (req_op == OP_UNMAP) ? '0
                                    : {12'd0, pa[PA_W-1:12], fl | E_PRESENT};
            res.flush      = 1'b1;
            res.flush_addr = va;
        end
        return res;
    endfunction

    function automatic logic [VA_W-1:0] compose_va(input logic [IDX_W-1:0] i4,
                                                   input logic [IDX_W-1:0] i3,
                                                   input logic [IDX_W-1:0] i2,
                                                   input logic [IDX_W-1:0] i1,
                                                   input logic [11:0] ofs);
        return {i4, i3, i2, i1, ofs};
    endfunction

    function automatic stim_row_t request_row(input logic req_op,
                                              input logic [VA_W-1:0] va,
                                              input logic [PA_W-1:0] pa,
                                              input logic [FLAGS_W-1:0] fl,
                                              input bit pinned,
                                              input status_t pin_status,
                                              input logic pin_flush);
        stim_row_t r;
        r.kind       = ROW_REQUEST;
        r.req_op     = req_op;
        r.va         = va;
        r.pa         = pa;
        r.flags      = fl;
        r.base       = '0;
        r.pinned     = pinned;
        r.pin_status = pin_status;
        r.pin_flush  = pin_flush;
        return r;
    endfunction

    function automatic stim_row_t base_row(input logic [BASE_W-1:0] new_base);
        stim_row_t r;
        r      = request_row(OP_MAP, '0, '0, '0, 1'b0, ST_DONE, 1'b0);
        r.kind = ROW_SET_BASE;
        r.base = new_base;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request word, hold it until taken, then log what it must produce.
    task automatic send_request(input logic req_op, input logic [VA_W-1:0] va,
                                input logic [PA_W-1:0] pa, input logic [FLAGS_W-1:0] fl,
                                input bit pinned, input status_t pin_status,
                                input logic pin_flush);
        walk_result_t predicted;
        in_valid   <= 1'b1;
        op         <= req_op;
        virt_addr  <= va;
        phys_addr  <= pa;
        page_flags <= fl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = walk_tables(req_op, va, pa, fl);
        if (predicted.walk_status == ST_DONE && req_op == OP_MAP)
            mapped_vas.push_back(va);
        if (pinned)
        begin
            predicted.walk_status = pin_status;
            predicted.flush       = pin_flush;
            predicted.flush_addr  = pin_flush ? va : '0;
        end
        pending_results.push_back(predicted);
        requests_sent++;
    endtask

    task automatic sender_gap();
        int unsigned gap;
        gap = idling_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Base writes only go in once the engine has nothing in flight.
    task automatic write_pool_base(input logic [BASE_W-1:0] new_base);
        wait_all_results();
        cfg_valid       <= 1'b1;
        table_pool_base <= new_base;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid        <= 1'b0;
        pool_base_shadow = new_base;
        base_writes++;
        // idle gap so back-to-back writes never drive cfg_valid twice at one edge
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, plus one long hold-off on request so the
    // output register and the walk both back up into in_stall.
    // ------------------------------------------------------------------
    initial
    begin : result_receiver
        int unsigned n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                for (n = 0; n < LONG_HOLD_CYCLES; n++)
                    @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 99) < 30)
            begin
                n = pick_gap();
                if (n == 0)
                    n = 1;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Every accepted result word is held against the oldest prediction.
    always @(posedge clk)
    begin : result_checker
        walk_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing pending: status %0d", status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                status_hits[want.walk_status]++;
                if (status !== want.walk_status)
                begin
                    $error("status: expected %0d, actual %0d", want.walk_status, status);
                    mismatches++;
                end
                if (invalidate !== want.flush)
                begin
                    $error("invalidate: expected %0d, actual %0d", want.flush, invalidate);
                    mismatches++;
                end
                if (invalidate_addr !== want.flush_addr)
                begin
                    $error("invalidate_addr: expected %h, actual %h",
                           want.flush_addr, invalidate_addr);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if no word moves on any channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int                   phase;
        int                   i;
        int unsigned          n_items;
        int unsigned          r;
        logic [63:0]          r64;
        logic [VA_W-1:0]      va;
        logic [VA_W-1:0]      seed_va;
        logic [PA_W-1:0]      pa;
        logic [FLAGS_W-1:0]   fl;
        logic                 req_op;
        logic [BASE_W-1:0]    phase_base;

        in_valid        <= 1'b0;
        op              <= OP_MAP;
        virt_addr       <= '0;
        phys_addr       <= '0;
        page_flags      <= '0;
        cfg_valid       <= 1'b0;
        table_pool_base <= POOL_BASE_RESET;
        rst_n           <= 1'b0;

        for (i = 0; i < POOL_PAGES*TABLE_ENTRIES; i++)
            tables_shadow[i] = '0;
        next_free_shadow = 1;
        pool_base_shadow = POOL_BASE_RESET;
        for (i = 0; i < 8; i++)
            status_hits[i] = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Pool pages are handed out in order 1..15, so the
        // comments track which pages each row takes.
        // unmap on an empty pool: root entry absent
        directed_rows.push_back(request_row(OP_UNMAP, '0, '0, '0, 1'b1, ST_ABSENT, 1'b0));
        // first map, takes pages 1..3
        directed_rows.push_back(request_row(OP_MAP, '0, {PA_W{1'b1}}, '0,
                                            1'b1, ST_DONE, 1'b1));
        directed_rows.push_back(request_row(OP_UNMAP, '0, '0, '0, 1'b0, ST_DONE, 1'b0));
        // leaf already empty: still cleared and flushed
        directed_rows.push_back(request_row(OP_UNMAP, '0, '0, '0, 1'b0, ST_DONE, 1'b0));
        directed_rows.push_back(request_row(OP_MAP, compose_va(0, 0, 0, 1, 12'hFFF), '0,
                                            12'hFFF, 1'b0, ST_DONE, 1'b0));
        // top of the address space, pages 4..6
        directed_rows.push_back(request_row(OP_MAP, {VA_W{1'b1}}, 52'hA_5A5A_5A5A_5000, '0,
                                            1'b0, ST_DONE, 1'b0));
        // large flag in the request lands in pages 7..9's directory entries
        directed_rows.push_back(request_row(OP_MAP, compose_va(1, 0, 0, 0, 0),
                                            52'h0_1234_5678_9000, 12'h080,
                                            1'b0, ST_DONE, 1'b0));
        // root entry ignores it, the next level stops the walk
        directed_rows.push_back(request_row(OP_MAP, compose_va(1, 0, 0, 5, 0), '0, '0,
                                            1'b1, ST_LARGE, 1'b0));
        directed_rows.push_back(request_row(OP_UNMAP, compose_va(1, 0, 0, 0, 0), '0, '0,
                                            1'b0, ST_DONE, 1'b0));
        // pages 10..12, then page 13 below a large third-level entry
        directed_rows.push_back(request_row(OP_MAP, compose_va(2, 3, 4, 0, 0), 52'h1000, '0,
                                            1'b0, ST_DONE, 1'b0));
        directed_rows.push_back(request_row(OP_MAP, compose_va(2, 3, 9, 0, 0), 52'h2000,
                                            12'h080, 1'b0, ST_DONE, 1'b0));
        directed_rows.push_back(request_row(OP_MAP, compose_va(2, 3, 9, 7, 0), 52'h3000, '0,
                                            1'b0, ST_DONE, 1'b0));
        // pages 14, 15 linked, then the pool runs dry mid-walk
        directed_rows.push_back(request_row(OP_MAP, compose_va(3, 0, 0, 0, 0), 52'h4000, '0,
                                            1'b0, ST_DONE, 1'b0));
        directed_rows.push_back(request_row(OP_MAP, compose_va(4, 0, 0, 0, 0), '0, '0,
                                            1'b1, ST_EXHAUSTED, 1'b0));
        directed_rows.push_back(request_row(OP_MAP, compose_va(3, 0, 0, 0, 0), '0, '0,
                                            1'b0, ST_DONE, 1'b0));
        // unmap through a missing directory level
        directed_rows.push_back(request_row(OP_UNMAP, compose_va(3, 0, 0, 0, 0), '0, '0,
                                            1'b0, ST_DONE, 1'b0));
        directed_rows.push_back(request_row(OP_UNMAP, compose_va(5, 0, 0, 0, 0), '0, '0,
                                            1'b0, ST_DONE, 1'b0));
        directed_rows.push_back(request_row(OP_MAP, compose_va(0, 0, 0, 511, 0), '0, '0,
                                            1'b0, ST_DONE, 1'b0));
        // base moved away: stored pointers now fall outside the pool
        directed_rows.push_back(base_row('0));
        directed_rows.push_back(request_row(OP_MAP, '0, '0, '0, 1'b1, ST_OUTSIDE, 1'b0));
        directed_rows.push_back(request_row(OP_UNMAP, compose_va(9, 0, 0, 0, 0), '0, '0,
                                            1'b0, ST_DONE, 1'b0));
        directed_rows.push_back(base_row({BASE_W{1'b1}}));
        directed_rows.push_back(request_row(OP_UNMAP, {VA_W{1'b1}}, '0, '0,
                                            1'b1, ST_OUTSIDE, 1'b0));
        directed_rows.push_back(base_row(POOL_BASE_RESET));

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_SET_BASE)
                write_pool_base(directed_rows[k].base);
            else
            begin
                send_request(directed_rows[k].req_op, directed_rows[k].va,
                             directed_rows[k].pa, directed_rows[k].flags,
                             directed_rows[k].pinned, directed_rows[k].pin_status,
                             directed_rows[k].pin_flush);
                sender_gap();
            end
        end

        // Random part. The pool is full by now, so most words reuse mapped
        // prefixes to get through the directory levels; the later phases
        // shift the base so stored pointers alias or fall outside the pool.
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin phase_base = POOL_BASE_RESET;       n_items = 200; end
                1: begin phase_base = POOL_BASE_RESET;       n_items = 150; end
                2: begin phase_base = POOL_BASE_RESET;       n_items = 100; end
                3: begin phase_base = POOL_BASE_RESET - 1;   n_items = 60;  end
                4: begin phase_base = '0;                    n_items = 60;  end
                5: begin phase_base = {BASE_W{1'b1}};        n_items = 60;  end
                6: begin
                    r64        = {$urandom, $urandom};
                    phase_base = r64[BASE_W-1:0];
                    n_items    = 60;
                end
                default: begin phase_base = POOL_BASE_RESET + 1; n_items = 60; end
            endcase
            write_pool_base(phase_base);
            // phase 1 runs back to back; phase 2 also holds the result side off
            idling_on = (phase != 1 && phase != 2);
            for (i = 0; i < int'(n_items); i++)
            begin
                if (phase == 2 && i == 10)
                    hold_request = 1'b1;
                if ((phase == 0 || phase == 3) && i == int'(n_items) / 2)
                    wait_all_results();
                r       = $urandom_range(0, 99);
                r64     = {$urandom, $urandom};
                seed_va = (mapped_vas.size() != 0)
                        ? mapped_vas[$urandom_range(0, mapped_vas.size() - 1)] : r64[VA_W-1:0];
                if (r < 60)
                    va = {seed_va[VA_W-1:21], r64[20:0]};
                else if (r < 75)
                    va = {seed_va[VA_W-1:30], r64[29:0]};
                else if (r < 85)
                    va = {seed_va[VA_W-1:39], r64[38:0]};
                else
                    va = r64[VA_W-1:0];
                r64    = {$urandom, $urandom};
                pa     = r64[PA_W-1:0];
                fl     = FLAGS_W'($urandom_range(0, 4095));
                req_op = ($urandom_range(0, 99) < 60) ? OP_MAP : OP_UNMAP;
                send_request(req_op, va, pa, fl, 1'b0, ST_DONE, 1'b0);
                sender_gap();
            end
        end
        idling_on = 1'b1;

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            mismatches++;
        end

        $display("Ran %0d map/unmap words over %0d pool base writes.",
                 requests_sent, base_writes);
        $display("Outcomes: %0d done, %0d large page, %0d pool full, %0d absent, %0d outside.",
                 status_hits[ST_DONE], status_hits[ST_LARGE], status_hits[ST_EXHAUSTED],
                 status_hits[ST_ABSENT], status_hits[ST_OUTSIDE]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
